// ===== src/tknd_pkg.sv =====
// tknd_pkg: widths, codes and struct types shared by the nearest-candidate store
// no dependencies; compiled before every other file of the block
`default_nettype none

package tknd_pkg;

    localparam int MAX_KEEP      = 64;
    localparam int POSITION_BITS = 48;
    localparam int DIST_W        = 31;
    localparam int KC_W          = 7;
    localparam int CNT_W         = $clog2(MAX_KEEP + 1);

    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [KC_W-1:0]          kc_t;

    // largest finite single, reported while the store is not full
    localparam dist_t FLT_MAX    = 31'h7F7F_FFFF;
    localparam kc_t   KEEP_RESET = 7'd64;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_DRAIN  = 2'd1,
        K_CLEAR  = 2'd2,
        K_STATUS = 2'd3
    } kind_t;

    typedef struct packed {
        dist_t d;
        pos_t  p;
    } entry_t;

    // row command, broadcast to every cell
    typedef struct packed {
        logic ins;
        logic shift;
        cnt_t bound;
    } cmd_t;

    typedef struct packed {
        logic le;
        logic match;
        logic worse;
        logic is_last;
    } cell_flags_t;

    typedef struct packed {
        logic  any_match;
        logic  match_worse;
        logic  any_worse;
        cnt_t  match_idx;
        dist_t last_d;
    } row_stat_t;

    typedef struct packed {
        logic  accepted;
        dist_t threshold;
        kc_t   held;
        logic  out_valid;
        dist_t out_distance;
        pos_t  out_position;
        logic  last;
    } res_t;

endpackage

`default_nettype wire

// ===== src/tknd_ifs.sv =====
// tknd_item_if and tknd_res_if: valid/ready channels of the candidate store
// depends on tknd_pkg
`default_nettype none

interface tknd_item_if;
    import tknd_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    dist_t       new_distance;
    pos_t        new_position;

    modport source (output valid, kind, new_distance, new_position, input ready);
    modport sink   (input valid, kind, new_distance, new_position, output ready);
endinterface

interface tknd_res_if;
    import tknd_pkg::*;

    logic        valid;
    logic        ready;
    logic        accepted;
    dist_t       threshold;
    kc_t         held;
    logic        out_valid;
    dist_t       out_distance;
    pos_t        out_position;
    logic        last;

    modport source (output valid, accepted, threshold, held, out_valid, out_distance,
                    out_position, last, input ready);
    modport sink   (input valid, accepted, threshold, held, out_valid, out_distance,
                    out_position, last, output ready);
endinterface

`default_nettype wire

// ===== src/tknd_cell.sv =====
// tknd_cell: one slot of the sorted row, compares against the broadcast candidate
// depends on tknd_pkg
`default_nettype none

module tknd_cell (
    input  wire                   clk,
    input  tknd_pkg::cnt_t        idx,
    input  tknd_pkg::cnt_t        total,
    input  tknd_pkg::cmd_t        cmd,
    input  tknd_pkg::entry_t      cand,
    input  wire                   left_le,
    input  tknd_pkg::entry_t      left_ent,
    input  tknd_pkg::entry_t      right_ent,
    output tknd_pkg::entry_t      ent,
    output tknd_pkg::cell_flags_t flags
);
    import tknd_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid;
    logic   worse;

    assign valid = idx < total;
    assign worse = valid && ((ent_reg.d > cand.d) ||
                             ((ent_reg.d == cand.d) && (ent_reg.p > cand.p)));

    assign flags.worse   = worse;
    assign flags.le      = valid && !worse;
    assign flags.match   = valid && (ent_reg.p == cand.p);
    assign flags.is_last = valid && (CNT_W'(idx + CNT_W'(1)) == total);

    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.shift)
        begin
            ent_next = right_ent;
        end
        else if (cmd.ins && (idx <= cmd.bound))
        begin
            if (!flags.le && left_le)
                ent_next = cand;
            else if (!left_le)
                ent_next = left_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

`default_nettype wire

// ===== src/tknd_row.sv =====
// tknd_row: chain of cells kept in ascending order, plus or-reductions of their flags
// depends on tknd_pkg and tknd_cell
`default_nettype none

module tknd_row (
    input  wire                  clk,
    input  tknd_pkg::cnt_t       total,
    input  tknd_pkg::cmd_t       cmd,
    input  tknd_pkg::entry_t     cand,
    output tknd_pkg::entry_t     head,
    output tknd_pkg::row_stat_t  stat
);
    import tknd_pkg::*;

    entry_t      ent [MAX_KEEP];
    cell_flags_t fl  [MAX_KEEP];

    for (genvar g = 0; g < MAX_KEEP; g++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;
        logic   left_le;

        // the head has nothing on its left that stays
        if (g == 0)
        begin : g_head
            assign left_ent = '0;
            assign left_le  = 1'b1;
        end
        else
        begin : g_mid
            assign left_ent = ent[g-1];
            assign left_le  = fl[g-1].le;
        end

        if (g == MAX_KEEP - 1)
        begin : g_tail
            assign right_ent = '0;
        end
        else
        begin : g_body
            assign right_ent = ent[g+1];
        end

        tknd_cell u_cell (
            .clk       (clk),
            .idx       (CNT_W'(g)),
            .total     (total),
            .cmd       (cmd),
            .cand      (cand),
            .left_le   (left_le),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .ent       (ent[g]),
            .flags     (fl[g])
        );
    end

    always_comb
    begin
        stat = '0;
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            stat.any_match   |= fl[i].match;
            stat.match_worse |= fl[i].match && fl[i].worse;
            stat.any_worse   |= fl[i].worse;
            stat.match_idx   |= fl[i].match ? CNT_W'(i) : '0;
            stat.last_d      |= fl[i].is_last ? ent[i].d : '0;
        end
    end

    assign head = ent[0];

endmodule

`default_nettype wire

// ===== src/topk_nearest_with_dedup_unit.sv =====
// topk_nearest_with_dedup_unit: bounded k-nearest store, unique positions, sorted drain
// insert, clear and status results pass the pending register, then the output register
// throughput: one item per cycle via broadcast row update; stalls on output or drain
// drain: one beat per kept entry, one per cycle unless output stalls; row shifts to head
// reset: held count 0, keep_count 64; cell contents stay undefined, no clearing pass
`default_nettype none

module topk_nearest_with_dedup_unit (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                keep_count_we,
    input  tknd_pkg::kc_t      keep_count,
    tknd_item_if.sink          item,
    tknd_res_if.source         result
);
    import tknd_pkg::*;

    typedef enum logic {
        S_RUN,
        S_DRAIN
    } state_t;

    state_t    state_reg, state_next;
    cnt_t      total_reg, total_next;
    kc_t       kc_reg, kc_next;
    logic      pend_reg, pend_next;
    logic      pend_acc_reg, pend_acc_next;
    logic      ov_reg, ov_next;
    res_t      res_reg, res_next;

    cmd_t      cmd;
    entry_t    cand;
    entry_t    head;
    row_stat_t stat;

    cnt_t      cap;
    dist_t     thr_now;
    logic      take_in;
    logic      out_free;
    logic      pend_move;
    logic      drain_emit;
    logic      acc_dec;
    logic      grow;
    cnt_t      bound;

    // the broadcast candidate is always the item on the input channel
    assign cand.d = item.new_distance;
    assign cand.p = item.new_position;

    tknd_row u_row (
        .clk   (clk),
        .total (total_reg),
        .cmd   (cmd),
        .cand  (cand),
        .head  (head),
        .stat  (stat)
    );

    // capacity clamps the register into 1..MAX_KEEP
    always_comb
    begin
        if (kc_reg == '0)
            cap = CNT_W'(1);
        else if (kc_reg > KC_W'(MAX_KEEP))
            cap = CNT_W'(MAX_KEEP);
        else
            cap = CNT_W'(kc_reg);
    end

    // pruning threshold of the row as it stands now
    assign thr_now = ((total_reg < cap) || (total_reg == '0)) ? FLT_MAX : stat.last_d;

    // handshake bookkeeping: a pending result moves into the output register when free
    assign out_free   = !ov_reg || result.ready;
    assign pend_move  = pend_reg && out_free;
    assign drain_emit = (state_reg == S_DRAIN) && !pend_reg && out_free;
    assign item.ready = (state_reg == S_RUN) && (!pend_reg || pend_move);
    assign take_in    = item.valid && item.ready;

    // insert decision
    // same position held: replace only if strictly better, removing that cell
    // free room: take the sorted slot, nothing removed
    // full: beat the worst entry, which falls off the end
    always_comb
    begin
        if (stat.any_match)
        begin
            acc_dec = stat.match_worse;
            bound   = stat.match_idx;
            grow    = 1'b0;
        end
        else if (total_reg < cap)
        begin
            acc_dec = 1'b1;
            bound   = total_reg;
            grow    = 1'b1;
        end
        else
        begin
            acc_dec = stat.any_worse;
            bound   = CNT_W'(total_reg - CNT_W'(1));
            grow    = 1'b0;
        end
    end

    assign cmd.ins   = take_in && (kind_t'(item.kind) == K_INSERT) && acc_dec;
    assign cmd.shift = drain_emit;
    assign cmd.bound = bound;

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        kc_next       = kc_reg;
        pend_next     = pend_reg;
        pend_acc_next = pend_acc_reg;
        ov_next       = ov_reg;
        res_next      = res_reg;

        if (keep_count_we)
            kc_next = keep_count;

        // output register: pending result, drain beat, or drained by the sink
        if (pend_move)
        begin
            pend_next             = 1'b0;
            ov_next               = 1'b1;
            res_next.accepted     = pend_acc_reg;
            res_next.threshold    = thr_now;
            res_next.held         = KC_W'(total_reg);
            res_next.out_valid    = 1'b0;
            res_next.out_distance = '0;
            res_next.out_position = '0;
            res_next.last         = 1'b1;
        end
        else if (drain_emit)
        begin
            ov_next               = 1'b1;
            res_next.accepted     = 1'b0;
            res_next.threshold    = FLT_MAX;
            res_next.held         = '0;
            res_next.out_valid    = 1'b1;
            res_next.out_distance = head.d;
            res_next.out_position = head.p;
            res_next.last         = (total_reg == CNT_W'(1));
            total_next            = CNT_W'(total_reg - CNT_W'(1));
            if (total_reg == CNT_W'(1))
                state_next = S_RUN;
        end
        else if (result.ready)
        begin
            ov_next = 1'b0;
        end

        if (take_in)
        begin
            pend_next     = 1'b1;
            pend_acc_next = 1'b0;
            case (kind_t'(item.kind))
                K_INSERT:
                begin
                    pend_acc_next = acc_dec;
                    if (acc_dec && grow)
                        total_next = CNT_W'(total_reg + CNT_W'(1));
                end
                K_DRAIN:
                begin
                    // an empty drain answers with one status-like beat
                    if (total_reg != '0)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DRAIN;
                    end
                end
                K_CLEAR:
                begin
                    total_next = '0;
                end
                default:
                begin
                    // status report only
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RUN;
            total_reg    <= '0;
            kc_reg       <= KEEP_RESET;
            pend_reg     <= 1'b0;
            pend_acc_reg <= 1'b0;
            ov_reg       <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            kc_reg       <= kc_next;
            pend_reg     <= pend_next;
            pend_acc_reg <= pend_acc_next;
            ov_reg       <= ov_next;
            res_reg      <= res_next;
        end
    end

    assign result.valid        = ov_reg;
    assign result.accepted     = res_reg.accepted;
    assign result.threshold    = res_reg.threshold;
    assign result.held         = res_reg.held;
    assign result.out_valid    = res_reg.out_valid;
    assign result.out_distance = res_reg.out_distance;
    assign result.out_position = res_reg.out_position;
    assign result.last         = res_reg.last;

    // the row never holds more than its cells
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_KEEP))
        else $error("held count above row size");

    // an accepted insert grows the row by at most one entry
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> (total_reg <= CNT_W'($past(total_reg) + CNT_W'(1))))
        else $error("insert grew held count by more than one");

    // the final drain beat returns the block to normal operation
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_emit && (total_reg == CNT_W'(1))) |=> (state_reg == S_RUN && total_reg == '0))
        else $error("drain did not finish after its last beat");

endmodule

`default_nettype wire
